/* hw/rtl/ps2mt_pkg.sv */
// Package for the PS/2 mouse packet tracker: shared types, register indexes
// and the cursor axis update function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

	localparam int COORD_BITS = 12;
	localparam int SIZE_W     = 13;
	localparam int EXT_W      = (SIZE_W > COORD_BITS + 2) ? SIZE_W : COORD_BITS + 2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

	localparam int HDR_SYNC_BIT   = 3;
	localparam int BTN_LEFT_BIT   = 0;
	localparam int BTN_RIGHT_BIT  = 1;
	localparam int BTN_MIDDLE_BIT = 2;

	typedef enum logic [1:0] {
		POS_HEADER,
		POS_XDELTA,
		POS_YDELTA
	} byte_pos_t;

	typedef struct packed {
		logic              enable;
		logic [SIZE_W-1:0] screen_width;
		logic [SIZE_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic                  left_button;
		logic                  right_button;
		logic                  middle_button;
	} res_t;

	localparam logic [EXT_W-1:0] SPAN = EXT_W'(1) << COORD_BITS;

	// pos + delta, clamped to 0 .. size-1; size 0 acts as 1, size above span as span
	function automatic logic [COORD_BITS-1:0] move_axis(
		input logic [COORD_BITS-1:0] pos,
		input logic signed [8:0]     delta,
		input logic [SIZE_W-1:0]     size
	);
		logic [EXT_W-1:0]             sz;
		logic [EXT_W-1:0]             lim;
		logic signed [COORD_BITS+1:0] nxt;
		logic [COORD_BITS-1:0]        res;
		sz = EXT_W'(size);
		if (sz == '0) begin
			sz = EXT_W'(1);
		end
		if (sz > SPAN) begin
			sz = SPAN;
		end
		lim = sz - EXT_W'(1);
		nxt = $signed({2'b00, pos}) + (COORD_BITS + 2)'(delta);
		if (nxt < 0) begin
			res = '0;
		end else if (EXT_W'($unsigned(nxt)) > lim) begin
			res = lim[COORD_BITS-1:0];
		end else begin
			res = nxt[COORD_BITS-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ps2mt_cfg_regs.sv */
// Configuration registers of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_cfg_regs import ps2mt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [SIZE_W-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.screen_width  <= WIDTH_RST;
			cfg_q.screen_height <= HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE: cfg_q.enable        <= cfg_data[0];
				REG_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ps2mt_decoder.sv */
// Input register, packet framing and cursor update of the PS/2 mouse tracker.
// Depends on ps2mt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_decoder import ps2mt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       aux_flag,
	input  wire logic [7:0] rx_byte,
	input  wire logic       res_space,
	output logic            res_push,
	output res_t            res
);

	logic                  in_valid_s1;
	logic                  aux_s1;
	logic [7:0]            byte_s1;
	byte_pos_t             pos_q, pos_d;
	logic [7:0]            header_q;
	logic [7:0]            xdelta_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [COORD_BITS-1:0] nx, ny;
	logic                  advance, take;
	logic signed [8:0]     dx, dy;

	assign advance  = in_valid_s1 && res_space;
	assign take     = advance && cfg.enable && aux_s1;
	assign in_ready = !in_valid_s1 || advance;

	assign dx = $signed({xdelta_q[7], xdelta_q});
	assign dy = -$signed({byte_s1[7], byte_s1});
	assign nx = move_axis(cur_x_q, dx, cfg.screen_width);
	assign ny = move_axis(cur_y_q, dy, cfg.screen_height);

	always_comb begin
		pos_d    = pos_q;
		res_push = 1'b0;
		if (take) begin
			case (pos_q)
				POS_HEADER: begin
					if (byte_s1[HDR_SYNC_BIT]) begin
						pos_d = POS_XDELTA;
					end
				end
				POS_XDELTA: pos_d = POS_YDELTA;
				POS_YDELTA: begin
					pos_d    = POS_HEADER;
					res_push = 1'b1;
				end
				default: pos_d = POS_HEADER;
			endcase
		end
	end

	assign res.pos_x         = nx;
	assign res.pos_y         = ny;
	assign res.left_button   = header_q[BTN_LEFT_BIT];
	assign res.right_button  = header_q[BTN_RIGHT_BIT];
	assign res.middle_button = header_q[BTN_MIDDLE_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			pos_q       <= POS_HEADER;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
		end else begin
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			pos_q <= pos_d;
			if (res_push) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			aux_s1  <= aux_flag;
			byte_s1 <= rx_byte;
		end
		if (take && pos_q == POS_HEADER) begin
			header_q <= byte_s1;
		end
		if (take && pos_q == POS_XDELTA) begin
			xdelta_q <= byte_s1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ps2mt_out_queue.sv */
// Two-entry result queue of the PS/2 mouse tracker; decouples the output
// handshake from packet processing. Depends on ps2mt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_out_queue import ps2mt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_data,
	output logic      space,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ps2_mouse_packet_tracker_unit.sv */
// PS/2 mouse packet tracker, top level.
// Depends on ps2mt_pkg, ps2mt_cfg_regs, ps2mt_decoder, ps2mt_out_queue.
//
// Takes one controller byte per cycle while in_ready is high; bytes from the
// mouse port are framed into three-byte packets (header must have bit 3 set)
// and, while enabled, each completed packet yields one result with the clamped
// absolute cursor and the three buttons. A byte is registered on accept and
// processed once the output queue has space; the result is registered into a
// two-entry output queue. Input ready drops only while that queue is full.
// Configuration writes are always ready and take effect on the next byte.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_tracker_unit import ps2mt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [SIZE_W-1:0]     cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  aux_flag,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [COORD_BITS-1:0]      pos_x,
	output logic [COORD_BITS-1:0]      pos_y,
	output logic                       left_button,
	output logic                       right_button,
	output logic                       middle_button
);

	cfg_t cfg;
	res_t res, out_res;
	logic res_push, res_space;

	ps2mt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ps2mt_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.aux_flag  (aux_flag),
		.rx_byte   (rx_byte),
		.res_space (res_space),
		.res_push  (res_push),
		.res       (res)
	);

	ps2mt_out_queue u_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.space     (res_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign pos_x         = out_res.pos_x;
	assign pos_y         = out_res.pos_y;
	assign left_button   = out_res.left_button;
	assign right_button  = out_res.right_button;
	assign middle_button = out_res.middle_button;

	a_push_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_space)
		else $error("result pushed into a full queue");

	a_push_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> cfg.enable)
		else $error("result produced while disabled");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && cfg.screen_width != '0) |->
		(EXT_W'(res.pos_x) < EXT_W'(cfg.screen_width)))
		else $error("cursor X outside screen width");

	a_push_leaves_queue: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> out_valid)
		else $error("pushed result not visible on output");

endmodule

`default_nettype wire
